// ===== rtl/core/rcfd_pkg.sv =====
// ----------------------------------------------------------------------------
// rcfd_pkg
// Shared types and constants of the packed RC channel frame decoder.
// ----------------------------------------------------------------------------
package rcfd_pkg;

    localparam int CH_W   = 11;
    localparam int FRAC_W = 20;
    localparam int MUL_W  = 19;
    localparam int PROD_W = 29;

    localparam logic [3:0] FIRST_PAYLOAD_BYTE = 4'd3;
    localparam logic [3:0] TYPE_BYTE          = 4'd2;
    localparam logic [3:0] LAST_PAYLOAD_BYTE  = 4'd13;
    localparam logic [3:0] IDLE_POSITION      = 4'd14;
    localparam int         STORE_DEPTH        = 10;

    typedef enum logic [1:0] {
        CFG_ADDRESS  = 2'd0,
        CFG_TYPE     = 2'd1,
        CFG_DEADBAND = 2'd2
    } t_cfg_index;

    localparam logic [7:0] ADDRESS_RESET  = 8'd200;
    localparam logic [7:0] TYPE_RESET     = 8'd22;
    localparam logic [6:0] DEADBAND_RESET = 7'd5;

    localparam logic [CH_W-1:0] CH_LO        = 11'd174;
    localparam logic [CH_W-1:0] CH_MED       = 11'd992;
    localparam logic [CH_W-1:0] CH_HI_WIDE   = 11'd1811;
    localparam logic [CH_W-1:0] CH_HI_NARROW = 11'd1808;
    localparam logic [CH_W-1:0] SWITCH_TH    = 11'd1700;
    localparam logic [CH_W-1:0] MODE_LO      = 11'd900;
    localparam logic [CH_W-1:0] MODE_HI      = 11'd1100;

    localparam logic [1:0] WING_IDLE = 2'd0;
    localparam logic [1:0] WING_HALF = 2'd1;
    localparam logic [1:0] WING_FULL = 2'd2;

    localparam logic [9:0] ROLL_SPAN  = 10'd400;
    localparam logic [6:0] AMP_SPAN   = 7'd80;
    localparam logic [6:0] YAW_SPAN   = 7'd100;
    localparam logic [6:0] SWEEP_SPAN = 7'd100;
    localparam logic [3:0] RATE_BASE  = 4'd5;
    localparam logic [6:0] YMAG_SPLIT = 7'd50;
    localparam logic [4:0] YMAG_MID   = 5'd15;

    // ceil(span * 2^FRAC_W / divisor): exact floor quotient over the offset range
    localparam logic [MUL_W-1:0] ROLL_M_LO  = MUL_W'((400 * (2 ** FRAC_W) + 817) / 818);
    localparam logic [MUL_W-1:0] ROLL_M_HI  = MUL_W'((400 * (2 ** FRAC_W) + 818) / 819);
    localparam logic [MUL_W-1:0] AMP_M_LO   = MUL_W'((80 * (2 ** FRAC_W) + 817) / 818);
    localparam logic [MUL_W-1:0] AMP_M_HI   = MUL_W'((80 * (2 ** FRAC_W) + 815) / 816);
    localparam logic [MUL_W-1:0] YAW_M_LO   = MUL_W'((100 * (2 ** FRAC_W) + 817) / 818);
    localparam logic [MUL_W-1:0] YAW_M_HI   = MUL_W'((100 * (2 ** FRAC_W) + 815) / 816);
    localparam logic [MUL_W-1:0] SWEEP_M_LO = MUL_W'((100 * (2 ** FRAC_W) + 817) / 818);
    localparam logic [MUL_W-1:0] SWEEP_M_HI = MUL_W'((100 * (2 ** FRAC_W) + 818) / 819);
    localparam logic [MUL_W-1:0] RATE_M     = MUL_W'((10 * (2 ** FRAC_W) + 817) / 818);
    localparam logic [MUL_W-1:0] YMAG_M     = MUL_W'((15 * (2 ** FRAC_W) + 49) / 50);

    typedef struct packed {
        logic [CH_W-1:0] roll_ch;
        logic [CH_W-1:0] amp_ch;
        logic [CH_W-1:0] rate_ch;
        logic [CH_W-1:0] yaw_ch;
        logic [CH_W-1:0] switch_ch;
        logic [CH_W-1:0] mode_ch;
        logic [CH_W-1:0] sweep_ch;
    } t_chan_set;

endpackage

// ===== rtl/core/rcfd_front.sv =====
// ----------------------------------------------------------------------------
// rcfd_front
// Tracks frame position, checks the header and unpacks the channel words.
// ----------------------------------------------------------------------------
module rcfd_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [7:0]          i_link_byte,
    input  logic                i_frame_begin,
    input  logic [7:0]          i_expected_address,
    input  logic [7:0]          i_expected_type,
    output logic                o_push_valid,
    input  logic                i_push_ready,
    output rcfd_pkg::t_chan_set o_push_data
);

    logic [3:0] r_pos;
    logic       r_hdr;
    logic [3:0] n_pos;
    logic       n_hdr;
    logic [7:0] r_store [rcfd_pkg::STORE_DEPTH];
    logic       w_accept;
    logic       w_active;
    logic       w_store_en;
    logic [3:0] w_store_idx;

    assign o_ready     = i_push_ready;
    assign w_accept    = i_valid && o_ready;
    assign w_active    = !i_frame_begin && (r_pos < rcfd_pkg::IDLE_POSITION);
    assign w_store_en  = w_accept && w_active && (r_pos >= rcfd_pkg::FIRST_PAYLOAD_BYTE)
                         && (r_pos < rcfd_pkg::LAST_PAYLOAD_BYTE);
    assign w_store_idx = r_pos - rcfd_pkg::FIRST_PAYLOAD_BYTE;

    always_comb begin
        n_pos = r_pos;
        n_hdr = r_hdr;
        if (i_frame_begin) begin
            n_hdr = (i_link_byte == i_expected_address);
            n_pos = 4'd1;
        end else if (w_active) begin
            if (r_pos == rcfd_pkg::TYPE_BYTE) begin
                n_hdr = r_hdr && (i_link_byte == i_expected_type);
            end
            if (r_pos == rcfd_pkg::LAST_PAYLOAD_BYTE) begin
                n_pos = rcfd_pkg::IDLE_POSITION;
            end else begin
                n_pos = r_pos + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= rcfd_pkg::IDLE_POSITION;
            r_hdr <= 1'b0;
        end else if (w_accept) begin
            r_pos <= n_pos;
            r_hdr <= n_hdr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_store_en) begin
            r_store[w_store_idx] <= i_link_byte;
        end
    end

    assign o_push_valid = i_valid && w_active && r_hdr
                          && (r_pos == rcfd_pkg::LAST_PAYLOAD_BYTE);

    // unpack little-endian 11-bit channels
    always_comb begin
        o_push_data.roll_ch   = {r_store[1][2:0], r_store[0]};
        o_push_data.amp_ch    = {r_store[2][5:0], r_store[1][7:3]};
        o_push_data.rate_ch   = {r_store[4][0], r_store[3], r_store[2][7:6]};
        o_push_data.yaw_ch    = {r_store[5][3:0], r_store[4][7:1]};
        o_push_data.switch_ch = {r_store[6][6:0], r_store[5][7:4]};
        o_push_data.mode_ch   = {r_store[8][1:0], r_store[7], r_store[6][7]};
        o_push_data.sweep_ch  = {i_link_byte, r_store[9][7:5]};
    end

`ifndef SYNTHESIS
    a_begin_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_frame_begin) |=> (r_pos == 4'd1))
        else $error("frame start did not restart position");

    a_pos_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pos != 4'd0) && (r_pos <= rcfd_pkg::IDLE_POSITION))
        else $error("byte position out of range");
`endif

endmodule

// ===== rtl/core/rcfd_queue.sv =====
// ----------------------------------------------------------------------------
// rcfd_queue
// Two-entry queue of channel words between the front and back parts.
// ----------------------------------------------------------------------------
module rcfd_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_wr_valid,
    output logic                o_wr_ready,
    input  rcfd_pkg::t_chan_set i_wr_data,
    output logic                o_rd_valid,
    input  logic                i_rd_ready,
    output rcfd_pkg::t_chan_set o_rd_data
);

    localparam int DEPTH = 2;

    rcfd_pkg::t_chan_set r_mem [DEPTH];
    logic                r_wr_ptr;
    logic                r_rd_ptr;
    logic [1:0]          r_count;
    logic                w_wr;
    logic                w_rd;

    assign o_wr_ready = (r_count != 2'(DEPTH));
    assign o_rd_valid = (r_count != 2'd0);
    assign o_rd_data  = r_mem[r_rd_ptr];
    assign w_wr       = i_wr_valid && o_wr_ready;
    assign w_rd       = o_rd_valid && i_rd_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (w_rd) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            unique case ({w_wr, w_rd})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

endmodule

// ===== rtl/core/rcfd_back.sv =====
// ----------------------------------------------------------------------------
// rcfd_back
// Three-stage map pipeline: offset and multiply, scale and dead band,
// yaw magnitude and output register.
// ----------------------------------------------------------------------------
module rcfd_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  rcfd_pkg::t_chan_set i_chan,
    input  logic [6:0]          i_deadband,
    output logic                o_valid,
    input  logic                i_ready,
    output logic signed [9:0]   o_roll_cmd,
    output logic [3:0]          o_beat_rate,
    output logic signed [7:0]   o_amplitude_cmd,
    output logic signed [7:0]   o_yaw_cmd,
    output logic [4:0]          o_yaw_magnitude,
    output logic                o_start_switch,
    output logic [1:0]          o_wing_mode,
    output logic signed [7:0]   o_sweep_cmd
);

    localparam int PW = rcfd_pkg::PROD_W;
    localparam int YW = rcfd_pkg::FRAC_W + 5;

    function automatic logic [9:0] seg_offset(input logic [10:0] ch, input logic [10:0] hi);
        logic [10:0] d;
        if (ch < rcfd_pkg::CH_MED) begin
            d = (ch < rcfd_pkg::CH_LO) ? 11'd0 : ch - rcfd_pkg::CH_LO;
        end else begin
            d = (ch > hi) ? hi - rcfd_pkg::CH_MED : ch - rcfd_pkg::CH_MED;
        end
        return d[9:0];
    endfunction

    function automatic logic [PW-1:0] scale(input logic [9:0] t,
                                            input logic [rcfd_pkg::MUL_W-1:0] m);
        return PW'(t) * PW'(m);
    endfunction

    logic adv1, adv2, adv3;
    logic r_v1, r_v2, r_v3;

    // stage 1
    logic          r_roll_lo, r_amp_lo, r_yaw_lo, r_sweep_lo;
    logic [PW-1:0] r_roll_p, r_amp_p, r_yaw_p, r_sweep_p, r_rate_p;
    logic          r_sw1;
    logic [1:0]    r_mode1;
    logic          w_roll_lo, w_amp_lo, w_yaw_lo, w_sweep_lo;
    logic [9:0]    w_rate_t;
    logic [1:0]    w_mode;

    // stage 2
    logic signed [9:0] r_roll2;
    logic [3:0]        r_rate2;
    logic signed [7:0] r_amp2, r_yaw2, r_sweep2;
    logic [6:0]        r_ay2;
    logic              r_sw2;
    logic [1:0]        r_mode2;
    logic [6:0]        w_amp_mag, w_yaw_mag, w_sweep_mag;
    logic [8:0]        w_roll_q;

    // stage 3
    logic          w_ym_lo;
    logic [5:0]    w_ym_t;
    logic [YW-1:0] w_ym_p;

    assign adv3    = !r_v3 || i_ready;
    assign adv2    = !r_v2 || adv3;
    assign adv1    = !r_v1 || adv2;
    assign o_ready = adv1;
    assign o_valid = r_v3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (adv1) begin
                r_v1 <= i_valid;
            end
            if (adv2) begin
                r_v2 <= r_v1;
            end
            if (adv3) begin
                r_v3 <= r_v2;
            end
        end
    end

    assign w_roll_lo  = i_chan.roll_ch  < rcfd_pkg::CH_MED;
    assign w_amp_lo   = i_chan.amp_ch   < rcfd_pkg::CH_MED;
    assign w_yaw_lo   = i_chan.yaw_ch   < rcfd_pkg::CH_MED;
    assign w_sweep_lo = i_chan.sweep_ch < rcfd_pkg::CH_MED;

    always_comb begin
        if (i_chan.rate_ch < rcfd_pkg::CH_LO) begin
            w_rate_t = 10'd0;
        end else if (i_chan.rate_ch >= rcfd_pkg::CH_MED) begin
            w_rate_t = 10'(rcfd_pkg::CH_MED - rcfd_pkg::CH_LO);
        end else begin
            w_rate_t = 10'(i_chan.rate_ch - rcfd_pkg::CH_LO);
        end
    end

    always_comb begin
        if (i_chan.mode_ch > rcfd_pkg::SWITCH_TH) begin
            w_mode = rcfd_pkg::WING_FULL;
        end else if (i_chan.mode_ch > rcfd_pkg::MODE_LO && i_chan.mode_ch < rcfd_pkg::MODE_HI) begin
            w_mode = rcfd_pkg::WING_HALF;
        end else begin
            w_mode = rcfd_pkg::WING_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_roll_lo  <= w_roll_lo;
            r_amp_lo   <= w_amp_lo;
            r_yaw_lo   <= w_yaw_lo;
            r_sweep_lo <= w_sweep_lo;
            r_roll_p   <= scale(seg_offset(i_chan.roll_ch, rcfd_pkg::CH_HI_WIDE),
                                w_roll_lo ? rcfd_pkg::ROLL_M_LO : rcfd_pkg::ROLL_M_HI);
            r_amp_p    <= scale(seg_offset(i_chan.amp_ch, rcfd_pkg::CH_HI_NARROW),
                                w_amp_lo ? rcfd_pkg::AMP_M_LO : rcfd_pkg::AMP_M_HI);
            r_yaw_p    <= scale(seg_offset(i_chan.yaw_ch, rcfd_pkg::CH_HI_NARROW),
                                w_yaw_lo ? rcfd_pkg::YAW_M_LO : rcfd_pkg::YAW_M_HI);
            r_sweep_p  <= scale(seg_offset(i_chan.sweep_ch, rcfd_pkg::CH_HI_WIDE),
                                w_sweep_lo ? rcfd_pkg::SWEEP_M_LO : rcfd_pkg::SWEEP_M_HI);
            r_rate_p   <= scale(w_rate_t, rcfd_pkg::RATE_M);
            r_sw1      <= i_chan.switch_ch > rcfd_pkg::SWITCH_TH;
            r_mode1    <= w_mode;
        end
    end

    assign w_roll_q    = r_roll_p[rcfd_pkg::FRAC_W +: 9];
    assign w_amp_mag   = r_amp_lo ? rcfd_pkg::AMP_SPAN - r_amp_p[rcfd_pkg::FRAC_W +: 7]
                                  : r_amp_p[rcfd_pkg::FRAC_W +: 7];
    assign w_yaw_mag   = r_yaw_lo ? rcfd_pkg::YAW_SPAN - r_yaw_p[rcfd_pkg::FRAC_W +: 7]
                                  : r_yaw_p[rcfd_pkg::FRAC_W +: 7];
    assign w_sweep_mag = r_sweep_lo ? rcfd_pkg::SWEEP_SPAN - r_sweep_p[rcfd_pkg::FRAC_W +: 7]
                                    : r_sweep_p[rcfd_pkg::FRAC_W +: 7];

    always_ff @(posedge i_clk) begin
        if (adv2) begin
            r_roll2  <= r_roll_lo ? 10'(w_roll_q) - rcfd_pkg::ROLL_SPAN : 10'(w_roll_q);
            r_rate2  <= rcfd_pkg::RATE_BASE + r_rate_p[rcfd_pkg::FRAC_W +: 4];
            if (w_amp_mag < i_deadband) begin
                r_amp2 <= 8'd0;
            end else begin
                r_amp2 <= r_amp_lo ? 8'd0 - 8'(w_amp_mag) : 8'(w_amp_mag);
            end
            r_yaw2   <= r_yaw_lo ? 8'd0 - 8'(w_yaw_mag) : 8'(w_yaw_mag);
            r_ay2    <= w_yaw_mag;
            r_sweep2 <= r_sweep_lo ? 8'd0 - 8'(w_sweep_mag) : 8'(w_sweep_mag);
            r_sw2    <= r_sw1;
            r_mode2  <= r_mode1;
        end
    end

    assign w_ym_lo = r_ay2 < rcfd_pkg::YMAG_SPLIT;
    assign w_ym_t  = w_ym_lo ? r_ay2[5:0] : 6'(r_ay2 - rcfd_pkg::YMAG_SPLIT);
    assign w_ym_p  = YW'(w_ym_t) * YW'(rcfd_pkg::YMAG_M);

    always_ff @(posedge i_clk) begin
        if (adv3) begin
            o_roll_cmd      <= r_roll2;
            o_beat_rate     <= r_rate2;
            o_amplitude_cmd <= r_amp2;
            o_yaw_cmd       <= r_yaw2;
            o_yaw_magnitude <= (w_ym_lo ? 5'd0 : rcfd_pkg::YMAG_MID)
                               + w_ym_p[rcfd_pkg::FRAC_W +: 5];
            o_start_switch  <= r_sw2;
            o_wing_mode     <= r_mode2;
            o_sweep_cmd     <= r_sweep2;
        end
    end

`ifndef SYNTHESIS
    a_roll_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 |-> (o_roll_cmd >= -10'sd400 && o_roll_cmd <= 10'sd400))
        else $error("roll word out of range");

    a_small_ranges: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 |-> (o_beat_rate >= 4'd5 && o_yaw_magnitude <= 5'd30
                  && o_wing_mode != 2'd3))
        else $error("rate, magnitude or mode word out of range");

    a_amp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 |-> (o_amplitude_cmd >= -8'sd80 && o_amplitude_cmd <= 8'sd80
                  && o_yaw_cmd >= -8'sd100 && o_yaw_cmd <= 8'sd100))
        else $error("amplitude or yaw word out of range");
`endif

endmodule

// ===== rtl/core/rc_frame_channel_decode_map_unit.sv =====
// Path: a matching frame's word passes the queue, then stage 1, stage 2 and output registers.
// Throughput: one byte per cycle while the two-entry queue is not full; output stalls fill it.
// Reset: synchronous, active low; position goes idle, header flag, queue and pipeline clear,
// and the registers return to address 200, type 22 and dead band 5. Payload bytes hold.
// ----------------------------------------------------------------------------
// rc_frame_channel_decode_map_unit
// Packed RC channel frame decoder with fixed control maps.
// ----------------------------------------------------------------------------
module rc_frame_channel_decode_map_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [7:0]        i_link_byte,
    input  logic              i_frame_begin,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic signed [9:0] o_roll_cmd,
    output logic [3:0]        o_beat_rate,
    output logic signed [7:0] o_amplitude_cmd,
    output logic signed [7:0] o_yaw_cmd,
    output logic [4:0]        o_yaw_magnitude,
    output logic              o_start_switch,
    output logic [1:0]        o_wing_mode,
    output logic signed [7:0] o_sweep_cmd,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [1:0]        i_cfg_index,
    input  logic [7:0]        i_cfg_data
);

    logic [7:0]          r_expected_address;
    logic [7:0]          r_expected_type;
    logic [6:0]          r_deadband;
    logic                w_push_valid;
    logic                w_push_ready;
    rcfd_pkg::t_chan_set w_push_data;
    logic                w_pop_valid;
    logic                w_pop_ready;
    rcfd_pkg::t_chan_set w_pop_data;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected_address <= rcfd_pkg::ADDRESS_RESET;
            r_expected_type    <= rcfd_pkg::TYPE_RESET;
            r_deadband         <= rcfd_pkg::DEADBAND_RESET;
        end else if (i_cfg_valid) begin
            unique case (rcfd_pkg::t_cfg_index'(i_cfg_index))
                rcfd_pkg::CFG_ADDRESS:  r_expected_address <= i_cfg_data;
                rcfd_pkg::CFG_TYPE:     r_expected_type    <= i_cfg_data;
                rcfd_pkg::CFG_DEADBAND: r_deadband         <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    rcfd_front u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_in_valid),
        .o_ready            (o_in_ready),
        .i_link_byte        (i_link_byte),
        .i_frame_begin      (i_frame_begin),
        .i_expected_address (r_expected_address),
        .i_expected_type    (r_expected_type),
        .o_push_valid       (w_push_valid),
        .i_push_ready       (w_push_ready),
        .o_push_data        (w_push_data)
    );

    rcfd_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (w_push_valid),
        .o_wr_ready (w_push_ready),
        .i_wr_data  (w_push_data),
        .o_rd_valid (w_pop_valid),
        .i_rd_ready (w_pop_ready),
        .o_rd_data  (w_pop_data)
    );

    rcfd_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (w_pop_valid),
        .o_ready         (w_pop_ready),
        .i_chan          (w_pop_data),
        .i_deadband      (r_deadband),
        .o_valid         (o_out_valid),
        .i_ready         (i_out_ready),
        .o_roll_cmd      (o_roll_cmd),
        .o_beat_rate     (o_beat_rate),
        .o_amplitude_cmd (o_amplitude_cmd),
        .o_yaw_cmd       (o_yaw_cmd),
        .o_yaw_magnitude (o_yaw_magnitude),
        .o_start_switch  (o_start_switch),
        .o_wing_mode     (o_wing_mode),
        .o_sweep_cmd     (o_sweep_cmd)
    );

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the packed RC channel frame decoder. Link bytes and
// register writes go in over valid/ready, the bytes with random gaps, and the
// output sees back-pressure; a software frame tracker with the control maps or
// a table row predicts every control word, compared field by field on leaving.
// ----------------------------------------------------------------------------
module tb;

    localparam logic [1:0] SPARE_INDEX = 2'd3;
    localparam int         RATE_TOP    = 15;
    localparam int         LINK_BYTES  = 1300;
    localparam int         CALM_BYTES  = 1100;
    localparam int         LONG_HOLD   = 300;

    typedef struct packed {
        logic signed [9:0] roll;
        logic [3:0]        rate;
        logic signed [7:0] amp;
        logic signed [7:0] yaw;
        logic [4:0]        ymag;
        logic              sw;
        logic [1:0]        mode;
        logic signed [7:0] sweep;
    } t_decoded;

    typedef struct packed {
        logic [7:0]  addr;
        logic [7:0]  ftype;
        logic [4:0]  len;
        logic [2:0]  lead;
        logic [87:0] chans;
        logic [6:0]  dband;
        logic        typed;
        t_decoded    want;
    } t_frame_row;

    localparam t_decoded WANT_CENTRE = '{roll: 10'sd0, rate: 4'd15, amp: 8'sd0, yaw: 8'sd0,
        ymag: 5'd0, sw: 1'b0, mode: rcfd_pkg::WING_HALF, sweep: 8'sd0};
    localparam t_decoded WANT_LOW = '{roll: -10'sd400, rate: 4'd5, amp: -8'sd80,
        yaw: -8'sd100, ymag: 5'd30, sw: 1'b0, mode: rcfd_pkg::WING_IDLE, sweep: -8'sd100};
    localparam t_decoded WANT_HIGH = '{roll: 10'sd400, rate: 4'd15, amp: 8'sd80,
        yaw: 8'sd100, ymag: 5'd30, sw: 1'b1, mode: rcfd_pkg::WING_FULL, sweep: 8'sd100};
    localparam t_decoded WANT_HIGH_FLAT = '{roll: 10'sd400, rate: 4'd15, amp: 8'sd0,
        yaw: 8'sd100, ymag: 5'd30, sw: 1'b1, mode: rcfd_pkg::WING_FULL, sweep: 8'sd100};

    // channels listed ch7 first
    t_frame_row frame_rows [18] = '{
        '{8'd200, 8'd22, 5'd14, 3'd3, {8{11'd992}}, 7'd5, 1'b1, WANT_CENTRE},
        '{8'd200, 8'd22, 5'd14, 3'd0, {88{1'b0}}, 7'd5, 1'b1, WANT_LOW},
        '{8'd200, 8'd22, 5'd14, 3'd0, {88{1'b1}}, 7'd5, 1'b1, WANT_HIGH},
        '{8'd200, 8'd22, 5'd14, 3'd0, {8{11'd174}}, 7'd5, 1'b1, WANT_LOW},
        '{8'd200, 8'd22, 5'd14, 3'd0, {11'd1811, 11'd0, 11'd1701, 11'd1701,
            11'd1808, 11'd173, 11'd941, 11'd1811}, 7'd5, 1'b0, '0},
        '{8'd200, 8'd22, 5'd14, 3'd0, {11'd175, 11'd2047, 11'd900, 11'd1700,
            11'd1807, 11'd991, 11'd952, 11'd993}, 7'd5, 1'b0, '0},
        '{8'd200, 8'd22, 5'd14, 3'd0, {11'd1810, 11'd5, 11'd901, 11'd1699,
            11'd991, 11'd993, 11'd1040, 11'd173}, 7'd5, 1'b0, '0},
        '{8'd200, 8'd22, 5'd14, 3'd0, {11'd991, 11'd9, 11'd1099, 11'd0,
            11'd993, 11'd500, 11'd1043, 11'd1000}, 7'd5, 1'b0, '0},
        '{8'd200, 8'd22, 5'd14, 3'd0, {11'd993, 11'd7, 11'd1100, 11'd2047,
            11'd175, 11'd1500, 11'd991, 11'd991}, 7'd5, 1'b0, '0},
        '{8'd201, 8'd22, 5'd14, 3'd0, {8{11'd992}}, 7'd5, 1'b0, '0},
        '{8'd200, 8'd23, 5'd14, 3'd0, {8{11'd992}}, 7'd5, 1'b0, '0},
        '{8'd200, 8'd22, 5'd9, 3'd0, {8{11'd992}}, 7'd5, 1'b0, '0},
        '{8'd200, 8'd22, 5'd18, 3'd0, {8{11'd1234}}, 7'd5, 1'b0, '0},
        '{8'd200, 8'd22, 5'd14, 3'd0, {88{1'b1}}, 7'd127, 1'b1, WANT_HIGH_FLAT},
        '{8'd200, 8'd22, 5'd14, 3'd0, {88{1'b0}}, 7'd80, 1'b1, WANT_LOW},
        '{8'd200, 8'd22, 5'd14, 3'd0, {88{1'b0}}, 7'd81, 1'b0, '0},
        '{8'd200, 8'd22, 5'd14, 3'd0, {8{11'd993}}, 7'd0, 1'b0, '0},
        '{8'd200, 8'd22, 5'd14, 3'd2, {11'd600, 11'd1400, 11'd1000, 11'd1750,
            11'd300, 11'd800, 11'd960, 11'd1650}, 7'd5, 1'b0, '0}
    };

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_ready;
    logic [7:0]        i_link_byte;
    logic              i_frame_begin;
    logic              o_out_valid;
    logic              i_out_ready;
    logic signed [9:0] o_roll_cmd;
    logic [3:0]        o_beat_rate;
    logic signed [7:0] o_amplitude_cmd;
    logic signed [7:0] o_yaw_cmd;
    logic [4:0]        o_yaw_magnitude;
    logic              o_start_switch;
    logic [1:0]        o_wing_mode;
    logic signed [7:0] o_sweep_cmd;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [1:0]        i_cfg_index;
    logic [7:0]        i_cfg_data;

    logic [7:0] cfg_addr = rcfd_pkg::ADDRESS_RESET;
    logic [7:0] cfg_type = rcfd_pkg::TYPE_RESET;
    logic [6:0] deadband = rcfd_pkg::DEADBAND_RESET;
    logic [3:0] frame_pos = rcfd_pkg::IDLE_POSITION;
    logic       header_ok = 1'b0;
    logic [7:0] payload_seen [rcfd_pkg::STORE_DEPTH];

    t_decoded decoded_due [$];
    t_decoded typed_word;
    bit       use_typed = 1'b0;
    int       fault_count = 0;
    int       bytes_sent = 0;
    bit       src_gaps = 1'b1;
    bit       sink_stalls = 1'b1;
    bit       sink_hold = 1'b0;
    bit       calm = 1'b0;

    rc_frame_channel_decode_map_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_link_byte     (i_link_byte),
        .i_frame_begin   (i_frame_begin),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_roll_cmd      (o_roll_cmd),
        .o_beat_rate     (o_beat_rate),
        .o_amplitude_cmd (o_amplitude_cmd),
        .o_yaw_cmd       (o_yaw_cmd),
        .o_yaw_magnitude (o_yaw_magnitude),
        .o_start_switch  (o_start_switch),
        .o_wing_mode     (o_wing_mode),
        .o_sweep_cmd     (o_sweep_cmd),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    function automatic int span_map(int x, int lo, int hi, int omin, int omax);
        int c;
        c = (x < lo) ? lo : ((x > hi) ? hi : x);
        return omin + ((c - lo) * (omax - omin)) / (hi - lo);
    endfunction

    function automatic int split_map(int x, int lo, int hi, int med, int omin, int omax);
        int omid;
        omid = (omin + omax) / 2;
        if (x < med) return span_map(x, lo, med, omin, omid);
        return span_map(x, med, hi, omid, omax);
    endfunction

    function automatic t_decoded decode_controls(input logic [87:0] bits);
        int       ch [8];
        int       amp, yaw, ay, db;
        t_decoded r;
        for (int k = 0; k < 8; k++) ch[k] = int'(bits[11*k +: 11]);
        r.roll = 10'(split_map(ch[0], int'(rcfd_pkg::CH_LO), int'(rcfd_pkg::CH_HI_WIDE),
            int'(rcfd_pkg::CH_MED), -int'(rcfd_pkg::ROLL_SPAN), int'(rcfd_pkg::ROLL_SPAN)));
        r.rate = 4'(span_map(ch[2], int'(rcfd_pkg::CH_LO), int'(rcfd_pkg::CH_MED),
            int'(rcfd_pkg::RATE_BASE), RATE_TOP));
        amp = split_map(ch[1], int'(rcfd_pkg::CH_LO), int'(rcfd_pkg::CH_HI_NARROW),
            int'(rcfd_pkg::CH_MED), -int'(rcfd_pkg::AMP_SPAN), int'(rcfd_pkg::AMP_SPAN));
        db = int'(deadband);
        if (-db < amp && amp < db) amp = 0;
        r.amp = 8'(amp);
        yaw = split_map(ch[3], int'(rcfd_pkg::CH_LO), int'(rcfd_pkg::CH_HI_NARROW),
            int'(rcfd_pkg::CH_MED), -int'(rcfd_pkg::YAW_SPAN), int'(rcfd_pkg::YAW_SPAN));
        r.yaw = 8'(yaw);
        ay = (yaw < 0) ? -yaw : yaw;
        r.ymag = 5'(split_map(ay, 0, int'(rcfd_pkg::YAW_SPAN), int'(rcfd_pkg::YMAG_SPLIT), 0,
            2 * int'(rcfd_pkg::YMAG_MID)));
        r.sw = (ch[4] > int'(rcfd_pkg::SWITCH_TH));
        if (ch[5] > int'(rcfd_pkg::SWITCH_TH)) r.mode = rcfd_pkg::WING_FULL;
        else if (ch[5] > int'(rcfd_pkg::MODE_LO) && ch[5] < int'(rcfd_pkg::MODE_HI))
            r.mode = rcfd_pkg::WING_HALF;
        else r.mode = rcfd_pkg::WING_IDLE;
        r.sweep = 8'(split_map(ch[7], int'(rcfd_pkg::CH_LO), int'(rcfd_pkg::CH_HI_WIDE),
            int'(rcfd_pkg::CH_MED), -int'(rcfd_pkg::SWEEP_SPAN), int'(rcfd_pkg::SWEEP_SPAN)));
        return r;
    endfunction

    task automatic track_link_byte(input logic [7:0] b, input logic fb);
        logic [87:0] bits;
        if (fb) begin
            header_ok = (b == cfg_addr);
            frame_pos = 4'd1;
        end else if (frame_pos < rcfd_pkg::IDLE_POSITION) begin
            if (frame_pos == rcfd_pkg::TYPE_BYTE) begin
                header_ok = header_ok && (b == cfg_type);
            end else if (frame_pos >= rcfd_pkg::FIRST_PAYLOAD_BYTE
                         && frame_pos < rcfd_pkg::LAST_PAYLOAD_BYTE) begin
                payload_seen[frame_pos - rcfd_pkg::FIRST_PAYLOAD_BYTE] = b;
            end
            if (frame_pos != rcfd_pkg::LAST_PAYLOAD_BYTE) begin
                frame_pos = frame_pos + 4'd1;
            end else begin
                frame_pos = rcfd_pkg::IDLE_POSITION;
                if (header_ok) begin
                    for (int k = 0; k < rcfd_pkg::STORE_DEPTH; k++)
                        bits[8*k +: 8] = payload_seen[k];
                    bits[87:80] = b;
                    decoded_due.push_back(use_typed ? typed_word : decode_controls(bits));
                end
            end
        end
    endtask

    task automatic note_fault(input string msg);
        fault_count++;
        $display("%0t %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic signed [31:0] got,
                               input logic signed [31:0] want);
        if (got !== want) note_fault($sformatf("%s: got %0d, want %0d", name, got, want));
    endtask

    always @(posedge i_clk) begin
        t_decoded w;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (decoded_due.size() == 0) begin
                note_fault("control word with none pending");
            end else begin
                w = decoded_due.pop_front();
                check_field("roll_cmd", o_roll_cmd, w.roll);
                check_field("beat_rate", o_beat_rate, w.rate);
                check_field("amplitude_cmd", o_amplitude_cmd, w.amp);
                check_field("yaw_cmd", o_yaw_cmd, w.yaw);
                check_field("yaw_magnitude", o_yaw_magnitude, w.ymag);
                check_field("start_switch", o_start_switch, w.sw);
                check_field("wing_mode", o_wing_mode, w.mode);
                check_field("sweep_cmd", o_sweep_cmd, w.sweep);
            end
        end
    end

    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (sink_hold) begin
                i_out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                sink_hold = 1'b0;
                i_out_ready <= 1'b1;
            end else if (!calm && sink_stalls && $urandom_range(0, 6) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge i_clk);
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    task automatic push_byte(input logic [7:0] b, input logic fb);
        i_in_valid    <= 1'b1;
        i_link_byte   <= b;
        i_frame_begin <= fb;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        track_link_byte(b, fb);
        bytes_sent++;
        if (!calm && src_gaps && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
    endtask

    task automatic send_frame(input logic [7:0] addr, input logic [7:0] ftype,
                              input logic [87:0] chans, input int len);
        logic [7:0] b;
        for (int j = 0; j < len; j++) begin
            if (j == 0) b = addr;
            else if (j == 2) b = ftype;
            else if (j >= 3 && j <= 13) b = chans[8*(j-3) +: 8];
            else b = 8'($urandom_range(0, 255));
            push_byte(b, j == 0);
        end
    endtask

    // drain: wait for every pending word, then out the pipeline latency
    task automatic settle_link();
        i_in_valid <= 1'b0;
        while (decoded_due.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic program_regs(input logic [7:0] addr, input logic [7:0] ftype,
                                input logic [7:0] db_data, input bit spare);
        logic [1:0] idx [4];
        logic [7:0] val [4];
        idx = '{rcfd_pkg::CFG_ADDRESS, rcfd_pkg::CFG_TYPE, rcfd_pkg::CFG_DEADBAND,
                SPARE_INDEX};
        val = '{addr, ftype, db_data, 8'($urandom_range(0, 255))};
        i_cfg_valid <= 1'b1;
        for (int k = 0; k < (spare ? 4 : 3); k++) begin
            i_cfg_index <= idx[k];
            i_cfg_data  <= val[k];
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
            case (idx[k])
                rcfd_pkg::CFG_ADDRESS:  cfg_addr = val[k];
                rcfd_pkg::CFG_TYPE:     cfg_type = val[k];
                rcfd_pkg::CFG_DEADBAND: deadband = val[k][6:0];
                default: ;
            endcase
        end
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [10:0] pick_channel();
        case ($urandom_range(0, 9))
            0: return 11'($urandom_range(0, 173));
            1: return 11'($urandom_range(170, 180));
            2: return 11'($urandom_range(985, 1000));
            3: return 11'($urandom_range(1695, 1705));
            4: return 11'($urandom_range(895, 905));
            5: return 11'($urandom_range(1095, 1105));
            6: return 11'($urandom_range(1800, 1815));
            7: return 11'($urandom_range(2035, 2047));
            default: return 11'($urandom_range(0, 2047));
        endcase
    endfunction

    function automatic logic [87:0] random_chans();
        logic [87:0] c;
        for (int k = 0; k < 8; k++) c[11*k +: 11] = pick_channel();
        return c;
    endfunction

    function automatic logic [7:0] pick_code(input logic [7:0] dflt);
        case ($urandom_range(0, 3))
            0: return 8'd0;
            1: return 8'd255;
            2: return dflt;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [7:0] pick_deadband();
        case ($urandom_range(0, 5))
            0: return 8'd0;
            1: return 8'd80;
            2: return 8'd127;
            3: return 8'd81;
            4: return 8'($urandom_range(0, 255));
            default: return 8'($urandom_range(1, 20));
        endcase
    endfunction

    initial begin
        int phase;
        int frames;
        logic [7:0] a, t;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_link_byte   = 8'd0;
        i_frame_begin = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = rcfd_pkg::CFG_ADDRESS;
        i_cfg_data    = 8'd0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (frame_rows[i]) begin
            if (frame_rows[i].dband != deadband) begin
                settle_link();
                program_regs(cfg_addr, cfg_type, {1'b0, frame_rows[i].dband}, 1'b0);
            end
            for (int k = 0; k < frame_rows[i].lead; k++)
                push_byte(8'($urandom_range(0, 255)), 1'b0);
            use_typed  = frame_rows[i].typed;
            typed_word = frame_rows[i].want;
            send_frame(frame_rows[i].addr, frame_rows[i].ftype, frame_rows[i].chans,
                int'(frame_rows[i].len));
            use_typed = 1'b0;
        end

        phase = 0;
        while (bytes_sent < LINK_BYTES) begin
            calm = (bytes_sent >= CALM_BYTES);
            settle_link();
            if (phase == 0) program_regs(8'd0, 8'd255, pick_deadband(), 1'b0);
            else if (phase == 1) program_regs(8'd255, 8'd0, pick_deadband(), 1'b0);
            else if (phase == 2 || $urandom_range(0, 2) != 0)
                program_regs(pick_code(rcfd_pkg::ADDRESS_RESET),
                    pick_code(rcfd_pkg::TYPE_RESET), pick_deadband(), phase == 2);
            src_gaps    = !calm && $urandom_range(0, 2) != 0;
            sink_stalls = !calm && $urandom_range(0, 2) != 0;
            frames = $urandom_range(4, 12);
            if (phase == 4) begin
                src_gaps  = 1'b0;
                sink_hold = 1'b1;
                frames    = 24;
            end
            for (int f = 0; f < frames; f++) begin
                case ((phase == 4) ? 0 : $urandom_range(0, 15))
                    11: send_frame(cfg_addr, cfg_type, random_chans(), $urandom_range(1, 13));
                    12: begin
                        a = cfg_addr ^ (8'd1 << $urandom_range(0, 7));
                        send_frame(a, cfg_type, random_chans(), 14);
                    end
                    13: begin
                        t = cfg_type ^ (8'd1 << $urandom_range(0, 7));
                        send_frame(cfg_addr, t, random_chans(), 14);
                    end
                    14: send_frame(cfg_addr, cfg_type, random_chans(), $urandom_range(15, 20));
                    15: repeat ($urandom_range(1, 6)) push_byte(8'($urandom_range(0, 255)), 1'b0);
                    default: send_frame(cfg_addr, cfg_type, random_chans(), 14);
                endcase
            end
            phase++;
        end

        calm = 1'b1;
        settle_link();
        repeat (10) @(posedge i_clk);
        if (fault_count == 0)
            $display("rc_frame_channel_decode_map_unit: match");
        else
            $display("rc_frame_channel_decode_map_unit: mismatch");
        $finish;
    end

    initial begin
        #(12 * 400000);
        $display("rc_frame_channel_decode_map_unit: mismatch");
        $finish;
    end

endmodule

// ===== rc_frame_channel_decode_map_unit.f =====
rtl/core/rcfd_pkg.sv
rtl/core/rcfd_front.sv
rtl/core/rcfd_queue.sv
rtl/core/rcfd_back.sv
rtl/core/rc_frame_channel_decode_map_unit.sv
verif/tb.sv
